### design/tqls_pkg.sv
// tqls_pkg: shared types, codes and defaults for the two-queue lottery scheduler
// request and response payload structs, field codes, queue control struct
// no dependencies
package tqls_pkg;

	// default sizes for the top level parameters
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int PID_BITS_DEF    = 8;

	// configuration port
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_QUANTUM = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PERCENT = 1'b1;

	localparam logic [15:0] QUANTUM_RESET = 16'd4;
	localparam logic [6:0]  PERCENT_RESET = 7'd70;

	// operation codes
	localparam logic OP_ADMIT    = 1'b0;
	localparam logic OP_SCHEDULE = 1'b1;

	// exit state of the outgoing process
	typedef enum logic [1:0] {
		EXIT_READY    = 2'd0,
		EXIT_BLOCKED  = 2'd1,
		EXIT_FINISHED = 2'd2,
		EXIT_INVALID  = 2'd3
	} exit_t;

	// where the process of a request went
	typedef enum logic [2:0] {
		ROUTE_NONE     = 3'd0,
		ROUTE_FIRST    = 3'd1,
		ROUTE_SECOND   = 3'd2,
		ROUTE_BLOCKED  = 3'd3,
		ROUTE_FINISHED = 3'd4,
		ROUTE_ERROR    = 3'd5
	} route_t;

	// sequencer states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} state_t;

	typedef struct packed {
		logic        operation;
		logic        admit_to_second;
		logic        current_valid;
		logic [7:0]  current_pid;
		logic [15:0] run_time;
		logic [1:0]  exit_state;
		logic [6:0]  random_value;
	} req_t;

	typedef struct packed {
		logic       selected_valid;
		logic [7:0] selected_pid;
		logic [2:0] routed_to;
		logic       overflow;
	} rsp_t;

	// per-queue commands from the scheduler core
	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctrl_t;

endpackage

### design/tqls_if.sv
// tqls_if: valid/ready channel interfaces for scheduler requests and responses
// depends on tqls_pkg for the payload structs
interface tqls_req_if;
	logic              valid;
	logic              ready;
	tqls_pkg::req_t    payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface tqls_rsp_if;
	logic              valid;
	logic              ready;
	tqls_pkg::rsp_t    payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### design/tqls_queue.sv
// tqls_queue: one ready queue of process ids in a synchronous memory
// circular buffer with head and count, registered read, write-to-read forwarding
// depends on tqls_pkg
module tqls_queue #(
	parameter int DEPTH    = tqls_pkg::QUEUE_DEPTH_DEF,
	parameter int PID_BITS = tqls_pkg::PID_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tqls_pkg::queue_ctrl_t  ctrl,
	input  logic [PID_BITS-1:0]    push_pid,
	output logic                   empty,
	output logic                   full,
	output logic [PID_BITS-1:0]    rd_pid
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [PID_BITS-1:0] mem [DEPTH];
	logic [PID_BITS-1:0] rd_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       tail;
	logic [AW-1:0]       head_next;
	logic [AW:0]         tail_sum;
	logic                push_ok;
	logic                fwd;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign push_ok = ctrl.push && !full;
	// popping an empty queue in the same cycle as its push returns the pushed id
	assign fwd     = ctrl.push && empty;
	assign rd_pid  = rd_q;

	// tail slot, wrapped for any depth
	always_comb begin
		tail_sum = {1'b0, head_q} + (AW+1)'(count_q);
		if (tail_sum >= (AW+1)'(DEPTH)) begin
			tail = AW'(tail_sum - (AW+1)'(DEPTH));
		end else begin
			tail = tail_sum[AW-1:0];
		end
		head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	end

	// memory write port
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[tail] <= push_pid;
		end
	end

	// memory read port, registered
	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			rd_q <= fwd ? push_pid : mem[head_q];
		end
	end

	// head and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.pop) begin
				head_q <= head_next;
			end
			case ({push_ok, ctrl.pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> (!empty || ctrl.push))
		else $error("pop from an empty queue");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok && !ctrl.pop |=> count_q == $past(count_q) + 1'b1)
		else $error("accepted push did not grow the queue");

endmodule

### design/two_queue_lottery_scheduler.sv
// two_queue_lottery_scheduler: top level of the two-queue lottery scheduler
// routes admitted and preempted ids into two ready queues and picks the next one
// depends on tqls_pkg, tqls_if and tqls_queue
//
// usage
//   req carries admit and schedule requests, rsp returns exactly one response
//   per request; both are valid/ready channels, a transfer when both are high.
//   cfg_we/cfg_index/cfg_data write quantum (index 0) and the queue one
//   percentage (index 1); write only while no request is in flight.
// sequence
//   a request is taken in the idle state, which pushes into a queue memory and
//   issues the head read; in the read state the response is formed from the
//   registered read data and loaded into the output register once rsp is free.
//   No new request is taken until the previous response has been loaded, as
//   the queue memories have a registered read.
// reset
//   both queues empty, quantum 4, percentage 70, no response pending.
// stalls
//   a finished response waits in the output register; the next request is
//   still taken, and its response waits in the read stage until rsp frees up.
module two_queue_lottery_scheduler #(
	parameter int QUEUE_DEPTH = tqls_pkg::QUEUE_DEPTH_DEF,
	parameter int PID_BITS    = tqls_pkg::PID_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	tqls_req_if.sink                              req,
	tqls_rsp_if.source                            rsp,
	input  logic                                  cfg_we,
	input  logic [tqls_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [tqls_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	tqls_pkg::state_t      state_q, state_next;
	tqls_pkg::req_t        p;
	tqls_pkg::queue_ctrl_t ctrl1, ctrl2;
	tqls_pkg::route_t      route, route_s1;
	tqls_pkg::rsp_t        out_q, result;

	logic [15:0]         quantum_q;
	logic [6:0]          percent_q;
	logic                acc;
	logic                load;
	logic                is_sched;
	logic                short_run;
	logic                push1, push2;
	logic                ne1, ne2;
	logic                pref1;
	logic                pop1, pop2;
	logic                ovf;
	logic                empty1, empty2, full1, full2;
	logic [PID_BITS-1:0] rd1, rd2;
	logic [PID_BITS-1:0] push_pid;
	logic [15:0]         pid_wide;
	logic [15:0]         sel_wide;
	logic                sel_valid_s1, sel_second_s1, ovf_s1;
	logic                out_valid_q;

	assign p        = req.payload;
	assign acc      = req.valid && req.ready;
	assign is_sched = (p.operation == tqls_pkg::OP_SCHEDULE);

	// id stored masked to the queue width
	assign pid_wide = 16'(p.current_pid);
	assign push_pid = pid_wide[PID_BITS-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= tqls_pkg::QUANTUM_RESET;
			percent_q <= tqls_pkg::PERCENT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tqls_pkg::CFG_QUANTUM: quantum_q <= cfg_data;
				tqls_pkg::CFG_PERCENT: percent_q <= cfg_data[6:0];
				default:               quantum_q <= quantum_q;
			endcase
		end
	end

	// route the outgoing or admitted process
	always_comb begin
		short_run = {p.run_time, 1'b0} < {1'b0, quantum_q};
		push1 = 1'b0;
		push2 = 1'b0;
		route = tqls_pkg::ROUTE_NONE;
		if (!is_sched) begin
			push1 = !p.admit_to_second;
			push2 = p.admit_to_second;
			route = p.admit_to_second ? tqls_pkg::ROUTE_SECOND : tqls_pkg::ROUTE_FIRST;
		end else if (p.current_valid) begin
			unique case (tqls_pkg::exit_t'(p.exit_state))
				tqls_pkg::EXIT_READY: begin
					push1 = short_run;
					push2 = !short_run;
					route = short_run ? tqls_pkg::ROUTE_FIRST : tqls_pkg::ROUTE_SECOND;
				end
				tqls_pkg::EXIT_BLOCKED:  route = tqls_pkg::ROUTE_BLOCKED;
				tqls_pkg::EXIT_FINISHED: route = tqls_pkg::ROUTE_FINISHED;
				default:                 route = tqls_pkg::ROUTE_ERROR;
			endcase
		end
	end

	// lottery pick over occupancy after the push
	always_comb begin
		ne1   = !empty1 || push1;
		ne2   = !empty2 || push2;
		pref1 = p.random_value < percent_q;
		pop1  = is_sched && (pref1 ? ne1 : (!ne2 && ne1));
		pop2  = is_sched && (pref1 ? (!ne1 && ne2) : ne2);
		ovf   = (push1 && full1) || (push2 && full2);
	end

	assign ctrl1 = '{push: acc && push1, pop: acc && pop1};
	assign ctrl2 = '{push: acc && push2, pop: acc && pop2};

	tqls_queue #(
		.DEPTH    (QUEUE_DEPTH),
		.PID_BITS (PID_BITS)
	) u_first_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl1),
		.push_pid (push_pid),
		.empty    (empty1),
		.full     (full1),
		.rd_pid   (rd1)
	);

	tqls_queue #(
		.DEPTH    (QUEUE_DEPTH),
		.PID_BITS (PID_BITS)
	) u_second_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl2),
		.push_pid (push_pid),
		.empty    (empty2),
		.full     (full2),
		.rd_pid   (rd2)
	);

	// request decision held while the memory read completes
	always_ff @(posedge clk) begin
		if (acc) begin
			sel_valid_s1  <= pop1 || pop2;
			sel_second_s1 <= pop2;
			route_s1      <= route;
			ovf_s1        <= ovf;
		end
	end

	// sequencer next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			tqls_pkg::ST_IDLE: if (acc) state_next = tqls_pkg::ST_READ;
			tqls_pkg::ST_READ: if (load) state_next = tqls_pkg::ST_IDLE;
			default:           state_next = tqls_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = (state_q == tqls_pkg::ST_IDLE);
		load      = (state_q == tqls_pkg::ST_READ) && (!out_valid_q || rsp.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tqls_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// response assembly
	always_comb begin
		sel_wide              = 16'(sel_second_s1 ? rd2 : rd1);
		result.selected_valid = sel_valid_s1;
		result.selected_pid   = sel_valid_s1 ? sel_wide[7:0] : 8'd0;
		result.routed_to      = route_s1;
		result.overflow       = ovf_s1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= result;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	a_ovf_route: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.payload.overflow |->
			rsp.payload.routed_to == tqls_pkg::ROUTE_FIRST ||
			rsp.payload.routed_to == tqls_pkg::ROUTE_SECOND)
		else $error("overflow without a queue push");

	a_idle_pid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.payload.selected_valid |-> rsp.payload.selected_pid == 8'd0)
		else $error("idle response carries a pid");

	a_single_pop: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> !(pop1 && pop2))
		else $error("both queues popped for one request");

endmodule

### test/two_queue_lottery_scheduler_test.sv
// two_queue_lottery_scheduler_test: self-checking bench for the two-queue lottery scheduler
// drives admit and schedule requests, predicts every response and compares it field by field
// depends on tqls_pkg, tqls_if and the two_queue_lottery_scheduler top level
module two_queue_lottery_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH  = tqls_pkg::QUEUE_DEPTH_DEF;
	localparam int FIRST  = 0;
	localparam int SECOND = 1;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [tqls_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [tqls_pkg::CFG_DATA_BITS-1:0] cfg_data;

	tqls_req_if req_ch();
	tqls_rsp_if rsp_ch();

	two_queue_lottery_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// shadow copy of the two ready queues and the registers
	logic [7:0] ready_store [2][DEPTH];
	logic [3:0] ready_head [2];
	logic [4:0] ready_count [2];
	logic [15:0] quantum_reg;
	logic [6:0] percent_reg;

	tqls_pkg::rsp_t pending_dispatches[$];
	int mismatch_count = 0;
	bit throttle = 1'b1;
	int stall_left = 0;

	function automatic bit enqueue_pid(int q, logic [7:0] id);
		logic [3:0] slot;
		if (ready_count[q] >= DEPTH)
			return 1'b0;
		slot = ready_head[q] + ready_count[q][3:0];
		ready_store[q][slot] = id;
		ready_count[q] = ready_count[q] + 1'b1;
		return 1'b1;
	endfunction

	function automatic logic [7:0] dequeue_pid(int q);
		logic [7:0] id;
		id = ready_store[q][ready_head[q]];
		ready_head[q] = ready_head[q] + 1'b1;
		ready_count[q] = ready_count[q] - 1'b1;
		return id;
	endfunction

	// expected response of one request, updating the shadow queues
	function automatic tqls_pkg::rsp_t next_dispatch(tqls_pkg::req_t r);
		tqls_pkg::rsp_t o;
		int target;
		int pref;
		logic [16:0] doubled;
		o = '0;
		if (r.operation == tqls_pkg::OP_ADMIT) begin
			target = r.admit_to_second ? SECOND : FIRST;
			o.routed_to = r.admit_to_second ? tqls_pkg::ROUTE_SECOND : tqls_pkg::ROUTE_FIRST;
			o.overflow = !enqueue_pid(target, r.current_pid);
		end else begin
			if (r.current_valid) begin
				case (tqls_pkg::exit_t'(r.exit_state))
					tqls_pkg::EXIT_READY: begin
						// short runners go to queue one
						doubled = {r.run_time, 1'b0};
						target = (doubled < {1'b0, quantum_reg}) ? FIRST : SECOND;
						o.routed_to = (target == FIRST) ? tqls_pkg::ROUTE_FIRST
							: tqls_pkg::ROUTE_SECOND;
						o.overflow = !enqueue_pid(target, r.current_pid);
					end
					tqls_pkg::EXIT_BLOCKED: o.routed_to = tqls_pkg::ROUTE_BLOCKED;
					tqls_pkg::EXIT_FINISHED: o.routed_to = tqls_pkg::ROUTE_FINISHED;
					default: o.routed_to = tqls_pkg::ROUTE_ERROR;
				endcase
			end
			// lottery pick with fallback to the other queue
			if (ready_count[FIRST] != 0 || ready_count[SECOND] != 0) begin
				pref = (r.random_value < percent_reg) ? FIRST : SECOND;
				if (ready_count[pref] == 0)
					pref = 1 - pref;
				o.selected_valid = 1'b1;
				o.selected_pid = dequeue_pid(pref);
			end
		end
		return o;
	endfunction

	function automatic tqls_pkg::req_t compose_request(logic op, logic to_second,
			logic cur_valid, logic [7:0] pid, logic [15:0] run_time,
			tqls_pkg::exit_t exit_code, logic [6:0] rnd);
		tqls_pkg::req_t r;
		r.operation = op;
		r.admit_to_second = to_second;
		r.current_valid = cur_valid;
		r.current_pid = pid;
		r.run_time = run_time;
		r.exit_state = exit_code;
		r.random_value = rnd;
		return r;
	endfunction

	function automatic tqls_pkg::req_t random_request(int admit_pct);
		tqls_pkg::req_t r;
		r.operation = ($urandom_range(0, 99) < admit_pct) ? tqls_pkg::OP_ADMIT
			: tqls_pkg::OP_SCHEDULE;
		r.admit_to_second = 1'($urandom_range(0, 1));
		r.current_valid = ($urandom_range(0, 9) != 0);
		r.current_pid = 8'($urandom_range(0, 255));
		// run times cluster around the quantum boundary, some span the full range
		if ($urandom_range(0, 2) == 0)
			r.run_time = 16'($urandom);
		else
			r.run_time = 16'($urandom_range(0, quantum_reg));
		if ($urandom_range(0, 1) == 0)
			r.exit_state = tqls_pkg::EXIT_READY;
		else
			r.exit_state = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0)
			r.random_value = 7'($urandom_range(100, 127));
		else
			r.random_value = 7'($urandom_range(0, 99));
		return r;
	endfunction

	// one request, with an optional idle burst ahead of it
	task automatic send_request(tqls_pkg::req_t r);
		if (throttle && $urandom_range(0, 9) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		do
			@(posedge clk);
		while (!req_ch.ready);
		pending_dispatches.push_back(next_dispatch(r));
	endtask

	task automatic wait_for_drain();
		req_ch.valid <= 1'b0;
		while (pending_dispatches.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_register(logic [tqls_pkg::CFG_INDEX_BITS-1:0] idx,
			logic [15:0] value);
		wait_for_drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tqls_pkg::CFG_QUANTUM)
			quantum_reg = value;
		else
			percent_reg = value[6:0];
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// response checker
	always @(posedge clk) begin
		tqls_pkg::rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_dispatches.size() == 0) begin
				$error("response with no request outstanding: %p", rsp_ch.payload);
				mismatch_count++;
			end else begin
				want = pending_dispatches.pop_front();
				check_field("selected_valid", want.selected_valid, rsp_ch.payload.selected_valid);
				check_field("selected_pid", want.selected_pid, rsp_ch.payload.selected_pid);
				check_field("routed_to", want.routed_to, rsp_ch.payload.routed_to);
				check_field("overflow", want.overflow, rsp_ch.payload.overflow);
			end
		end
	end

	// response side back-pressure in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (throttle && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(0, 16);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// edge cases at reset settings: empty picks, fallback, every exit, overflow
	task automatic test_directed_cases();
		send_request(compose_request(tqls_pkg::OP_SCHEDULE, 1'b0, 1'b0, 8'h00, 16'h0000,
			tqls_pkg::EXIT_READY, 7'd0));
		send_request(compose_request(tqls_pkg::OP_ADMIT, 1'b1, 1'b0, 8'h00, 16'h0000,
			tqls_pkg::EXIT_READY, 7'd0));
		send_request(compose_request(tqls_pkg::OP_ADMIT, 1'b0, 1'b1, 8'hFF, 16'hFFFF,
			tqls_pkg::EXIT_INVALID, 7'd127));
		send_request(compose_request(tqls_pkg::OP_SCHEDULE, 1'b0, 1'b1, 8'h3C, 16'h0000,
			tqls_pkg::EXIT_BLOCKED, 7'd99));
		send_request(compose_request(tqls_pkg::OP_SCHEDULE, 1'b1, 1'b1, 8'hC3, 16'h0000,
			tqls_pkg::EXIT_FINISHED, 7'd127));
		send_request(compose_request(tqls_pkg::OP_SCHEDULE, 1'b0, 1'b1, 8'h5A, 16'h0000,
			tqls_pkg::EXIT_INVALID, 7'd0));
		// preempted short runner is queued and picked again at once
		send_request(compose_request(tqls_pkg::OP_SCHEDULE, 1'b0, 1'b1, 8'h11, 16'd1,
			tqls_pkg::EXIT_READY, 7'd0));
		send_request(compose_request(tqls_pkg::OP_SCHEDULE, 1'b0, 1'b1, 8'h22, 16'd2,
			tqls_pkg::EXIT_READY, 7'd99));
		send_request(compose_request(tqls_pkg::OP_SCHEDULE, 1'b0, 1'b1, 8'hA5, 16'hFFFF,
			tqls_pkg::EXIT_READY, 7'd0));
		// fill queue one past its depth
		for (int i = 0; i <= DEPTH; i++)
			send_request(compose_request(tqls_pkg::OP_ADMIT, 1'b0, 1'b0, 8'(i * 17), 16'h0000,
				tqls_pkg::EXIT_READY, 7'd0));
		send_request(compose_request(tqls_pkg::OP_SCHEDULE, 1'b0, 1'b1, 8'h96, 16'h0000,
			tqls_pkg::EXIT_READY, 7'd69));
	endtask

	// random traffic under several quantum and percentage settings
	task automatic test_lottery_settings();
		logic [15:0] quanta [6] = '{16'd4, 16'd0, 16'd65535, 16'd1, 16'd1000, 16'd20};
		logic [6:0] percents [6] = '{7'd70, 7'd50, 7'd100, 7'd0, 7'd30, 7'd99};
		int admit_pct;
		admit_pct = 35;
		for (int p = 0; p < 6; p++) begin
			write_register(tqls_pkg::CFG_QUANTUM, quanta[p]);
			write_register(tqls_pkg::CFG_PERCENT, {9'b0, percents[p]});
			for (int i = 0; i < 175; i++) begin
				// alternate filling, draining and balanced stretches
				if (i % 32 == 0) begin
					case ($urandom_range(0, 2))
						0: admit_pct = 70;
						1: admit_pct = 10;
						default: admit_pct = 35;
					endcase
					throttle = ($urandom_range(0, 3) != 0);
				end
				if (p == 0 && i == 88)
					wait_for_drain();
				send_request(random_request(admit_pct));
			end
		end
	endtask

	// closing stretch at full rate on both sides
	task automatic test_quiet_tail();
		throttle = 1'b0;
		write_register(tqls_pkg::CFG_QUANTUM, 16'd12);
		write_register(tqls_pkg::CFG_PERCENT, 16'd70);
		for (int i = 0; i < 100; i++)
			send_request(random_request(40));
	endtask

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		cfg_we <= 1'b0;
		cfg_index <= tqls_pkg::CFG_QUANTUM;
		cfg_data <= '0;
		ready_head = '{default: '0};
		ready_count = '{default: '0};
		quantum_reg = tqls_pkg::QUANTUM_RESET;
		percent_reg = tqls_pkg::PERCENT_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_lottery_settings();
		test_quiet_tail();

		wait_for_drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// hang guard
	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
design/tqls_pkg.sv
design/tqls_if.sv
design/tqls_queue.sv
design/two_queue_lottery_scheduler.sv
test/two_queue_lottery_scheduler_test.sv
